@@ hw/rtl/tdp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared constants and types for the trial-division primality tester.
// ----------------------------------------------------------------------------
package tdp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  typedef logic signed [31:0] candidate_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/tdp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdp_in_if / tdp_out_if
// Valid/ready channels for candidate values and prime flags.
// ----------------------------------------------------------------------------
interface tdp_in_if;
  logic                valid;
  logic                ready;
  tdp_pkg::candidate_t candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_out_if;
  logic valid;
  logic ready;
  logic prime_flag;

  modport source (output valid, output prime_flag, input ready);
  modport sink   (input valid, input prime_flag, output ready);
endinterface

@@ hw/rtl/trial_division_primality_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_primality_test
// Sequencing: negative, even and values below 3 go from idle straight to done;
// 3, 5 and 7 pass one check; otherwise each odd trial divisor takes a check
// and VALUE_WIDTH steps of the bit-serial restoring remainder unit (up to
// ~23170 divisors at 32 bits).
// Throughput: one item at a time; src.ready is high only while idle.
// Reset (rst, synchronous) returns the sequencer to idle and drops dst.valid.
// ----------------------------------------------------------------------------
module trial_division_primality_test (
  input  logic            clk,
  input  logic            rst,
  tdp_in_if.sink          src,
  tdp_out_if.source       dst
);
  import tdp_pkg::*;

  localparam int VW = VALUE_WIDTH;

  state_t                state, state_next;
  logic [VW-1:0]         n, n_next;          // value under test
  logic [VW-1:0]         d, d_next;          // current odd divisor
  logic [2*VW-1:0]       sq, sq_next;        // d*d, kept incrementally
  logic [VW:0]           rem, rem_next;      // partial remainder
  logic [VW-1:0]         dvd, dvd_next;      // dividend bits still to shift in
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic                  flag, flag_next;

  logic [VW-1:0]         raw;
  logic                  raw_neg;
  logic [VW:0]           rem_sh;
  logic                  sub_ok;
  logic [VW:0]           rem_step;
  logic                  last_step;
  logic                  too_big;

  assign raw     = src.candidate[VW-1:0];
  assign raw_neg = raw[VW-1];

  // one restoring-division step per cycle
  assign rem_sh    = {rem[VW-1:0], dvd[VW-1]};
  assign sub_ok    = rem_sh >= {1'b0, d};
  assign rem_step  = sub_ok ? (rem_sh - {1'b0, d}) : rem_sh;
  assign last_step = cnt == CNT_W'(VW - 1);
  assign too_big   = sq > {{VW{1'b0}}, n};

  assign src.ready      = state == S_IDLE;
  assign dst.valid      = state == S_DONE;
  assign dst.prime_flag = flag;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (src.valid) begin
          if (raw_neg || raw < VW'(3) || !raw[0]) state_next = S_DONE;
          else state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (too_big) state_next = S_DONE;
        else state_next = S_DIV;
      end
      S_DIV: begin
        if (last_step) begin
          if (rem_step == '0) state_next = S_DONE;
          else state_next = S_CHECK;
        end
      end
      S_DONE: begin
        if (dst.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    n_next    = n;
    d_next    = d;
    sq_next   = sq;
    rem_next  = rem;
    dvd_next  = dvd;
    cnt_next  = cnt;
    flag_next = flag;
    unique case (state)
      S_IDLE: begin
        n_next    = raw;
        d_next    = VW'(3);
        sq_next   = (2*VW)'(9);
        flag_next = !raw_neg && raw == VW'(2);
      end
      S_CHECK: begin
        rem_next  = '0;
        dvd_next  = n;
        cnt_next  = '0;
        flag_next = 1'b1;
      end
      S_DIV: begin
        rem_next = rem_step;
        dvd_next = {dvd[VW-2:0], 1'b0};
        cnt_next = cnt + CNT_W'(1);
        if (last_step) begin
          if (rem_step == '0) begin
            flag_next = 1'b0;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            d_next  = d + VW'(2);
            sq_next = sq + {{(VW-2){1'b0}}, d, 2'b00} + (2*VW)'(4);
          end
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    n    <= n_next;
    d    <= d_next;
    sq   <= sq_next;
    rem  <= rem_next;
    dvd  <= dvd_next;
    cnt  <= cnt_next;
    flag <= flag_next;
  end

endmodule

@@ test/trial_division_primality_test_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_primality_test_tb
// Sends signed candidates into the primality tester and checks every returned
// flag against an in-bench trial-division predictor. The run starts with corner
// values, including the largest positive value, which is a slow prime. Random
// values follow, kept mostly cheap. Both channels idle at random, the result
// side holds off for a long stretch, and the sender drains once mid-run.
// ----------------------------------------------------------------------------
module trial_division_primality_test_tb;

  import tdp_pkg::candidate_t;
  import tdp_pkg::VALUE_WIDTH;

  localparam int          RANDOM_ITEMS = 100;
  localparam int          IDLE_PCT     = 18;
  localparam int          HOLD_AT      = 30;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          TAIL_CYCLES  = 20;
  // the slowest pass is dominated by the 2^31-1 search
  localparam int unsigned CYCLE_LIMIT  = 5_000_000;

  class prime_scoreboard;
    bit          expected_flags[$];
    int unsigned errors;
    int unsigned results;

    function bit is_prime_value(candidate_t v);
      longint unsigned mask;
      longint unsigned n;
      longint unsigned d;
      mask = ((64'd1 << (VALUE_WIDTH - 1)) * 2) - 1;
      n    = 64'(unsigned'(v)) & mask;
      if (n[VALUE_WIDTH-1]) return 1'b0;
      if (n < 2) return 1'b0;
      if (n == 2) return 1'b1;
      if (!n[0]) return 1'b0;
      // d <= n/d keeps the bound exact without forming d*d
      d = 3;
      while (d <= n / d) begin
        if (n % d == 0) return 1'b0;
        d += 2;
      end
      return 1'b1;
    endfunction

    function void note_candidate(candidate_t v);
      expected_flags.push_back(is_prime_value(v));
    endfunction

    function void check_flag(logic flag);
      bit want;
      results++;
      if (expected_flags.size() == 0) begin
        $error("prime_flag: expected none, actual %0b", flag);
        errors++;
        return;
      end
      want = expected_flags.pop_front();
      if (flag !== want) begin
        $error("prime_flag: expected %0b, actual %0b", want, flag);
        errors++;
      end
    endfunction

    function int pending();
      return expected_flags.size();
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst;
  bit              calm = 1'b0;
  int unsigned     cycles = 0;
  prime_scoreboard sb = new();

  candidate_t corner_values[$] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd8, 32'd9, 32'd15,
    32'd25, 32'd49, 32'd121, 32'd63001, 32'd65521,
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
    32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h7FFF_FFFF
  };

  tdp_in_if  in_ch ();
  tdp_out_if out_ch ();

  trial_division_primality_test uut (
    .clk (clk),
    .rst (rst),
    .src (in_ch),
    .dst (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly cheap values; big ones are negative, even or carry a small factor
  function automatic candidate_t random_candidate();
    int unsigned pick;
    int unsigned factor;
    pick = $urandom_range(99);
    if (pick < 40) return candidate_t'($urandom_range(4095));
    if (pick < 50) return candidate_t'($urandom_range(65535, 4096));
    if (pick < 65) return candidate_t'($urandom | 32'h8000_0000);
    if (pick < 80) return candidate_t'($urandom & 32'hFFFF_FFFE);
    if (pick < 95) begin
      factor = 3 + 2 * $urandom_range(5);
      return candidate_t'(factor * $urandom_range(32'h7FFF_FFFF / factor, 1));
    end
    return candidate_t'($urandom_range(16));
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_candidate(input candidate_t v);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.candidate <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_candidate(v);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid === 1'b1 && out_ch.ready) begin
        sb.check_flag(out_ch.prime_flag);
        if (sb.results == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int item;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.candidate <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_values[i]) send_candidate(corner_values[i]);
    in_ch.valid <= 1'b0;
    wait_drained();

    for (item = 0; item < RANDOM_ITEMS; item++) begin
      calm = (item >= 40 && item < 65);
      send_candidate(random_candidate());
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
